[rtl/core/swdd_pkg.sv]
// Shared constants and types for the sliding-window distinct detector.
package swdd_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int SYM_W          = 8;
  localparam int SYM_DEPTH      = 1 << SYM_W;
  localparam int CNT_W          = 32;
  localparam int WIN_W          = 5;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd14;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  // Register index, taken from the word address bit of paddr
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Output queue depth: covers the registered RAM read in flight at full rate
  localparam int OQ_DEPTH = 3;

  typedef struct packed {
    logic             window_distinct;
    logic             first_marker;
    logic [CNT_W-1:0] bytes_seen;
  } swdd_result_t;

endpackage

[rtl/core/swdd_if.sv]
// Stream interfaces for the symbol input channel and the result channel.
interface swdd_in_if
  import swdd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface swdd_out_if
  import swdd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             window_distinct;
  logic             first_marker;
  logic [CNT_W-1:0] bytes_seen;

  modport source (output valid, output window_distinct, output first_marker,
                  output bytes_seen, input ready);
  modport sink   (input valid, input window_distinct, input first_marker,
                  input bytes_seen, output ready);
endinterface

[rtl/core/sliding_window_distinct_detector_unit.sv]
// Top level of the sliding-window distinct detector: last-seen table, run tracker, output queue.
//
//   channel | direction | handshake              | beat payload
//   --------+-----------+------------------------+---------------------------------------
//   in_ch   | sink      | valid/ready            | symbol[7:0]
//   out_ch  | source    | valid/ready            | window_distinct, first_marker,
//           |           |                        | bytes_seen[31:0]
//   cfg     | APB slave | psel/penable, pready=1 | window_size at byte address 0
//
// One symbol per clock sustained while out_ch is ready; results pass the s1 register, then the output queue.
// The rate is set by the last-seen table RAM: one lookup and one write-back per beat,
// with the write of the previous beat forwarded to the next lookup.
// Reset (rst_n low, synchronous) clears the 256 entry-valid flops directly; no
// clearing pass is run. in_ch.ready stays low while rst_n is low, and the block takes
// beats as soon as rst_n is high.
// in_ch.ready drops only when the three-entry output queue plus the beat in flight
// is full, i.e. after out_ch stalls; a stall on out_ch never drops a result.
//
// Method: for each byte value the table holds the position of its last occurrence.
// The length of the all-distinct run ending at the current beat is
// min(previous run + 1, distance to the last occurrence), capped at MAX_WINDOW.
// The window of W bytes is all distinct exactly when that run reaches W.
// A background scrubber sweeps the table one entry per cycle and drops entries
// of age MAX_WINDOW or more, so the narrow position counter never aliases.
module sliding_window_distinct_detector_unit
  import swdd_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swdd_in_if.sink               in_ch,
  swdd_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Run length needs to hold 0..MAX_WINDOW. Positions only need to stay unique
  // across the longest time an entry can stay valid, which the scrubber bounds.
  localparam int RUN_W  = $clog2(MAX_WINDOW + 1);
  localparam int POS_W  = $clog2(2 * SYM_DEPTH + 4 * MAX_WINDOW);
  localparam int ADDR_W = $clog2(SYM_DEPTH);
  localparam int QP_W   = $clog2(OQ_DEPTH);
  localparam int QC_W   = $clog2(OQ_DEPTH + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_WINDOW);
  localparam logic [POS_W-1:0] AGE_MAX = POS_W'(MAX_WINDOW);

  // ---------------------------------------------------------------- config port
  logic [WIN_W-1:0] window_size_r;
  logic             cfg_wr;
  logic [RUN_W-1:0] win_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? CFG_DATA_W'(window_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WIN_RESET;
    end else if (cfg_wr) begin
      window_size_r <= pwdata[WIN_W-1:0];
    end
  end

  // Clamp the programmed window into 1..MAX_WINDOW
  always_comb begin
    if (window_size_r == '0) begin
      win_eff = RUN_W'(1);
    end else if (32'(window_size_r) > 32'(MAX_WINDOW)) begin
      win_eff = RUN_MAX;
    end else begin
      win_eff = RUN_W'(window_size_r);
    end
  end

  // ---------------------------------------------------------------- input stage
  logic             in_acc;
  logic             in_rdy;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] bc_r;
  logic [CNT_W-1:0] bc_nxt;
  logic             s1_v_r;
  logic [SYM_W-1:0] s1_sym_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic [QC_W-1:0]  q_cnt_r;

  // Admit a beat only out of reset and while the queue has room for it and the beat in flight
  assign in_rdy      = rst_n && ((32'(q_cnt_r) + 32'(s1_v_r)) < OQ_DEPTH);
  assign in_ch.ready = in_rdy;
  assign in_acc      = in_ch.valid && in_rdy;
  assign bc_nxt      = (bc_r == '1) ? bc_r : bc_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bc_r   <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      if (in_acc) begin
        pos_r <= pos_r + POS_W'(1);
        bc_r  <= bc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sym_r <= in_ch.symbol;
      s1_pos_r <= pos_r;
      s1_cnt_r <= bc_nxt;
    end
  end

  // ---------------------------------------------------------------- last-seen table
  logic [POS_W-1:0]     rd_pos;
  logic [POS_W-1:0]     sc_pos;
  logic [ADDR_W-1:0]    sc_ptr_r;
  logic [ADDR_W-1:0]    sc_e1_r;
  logic                 sc_v1_r;
  logic [SYM_DEPTH-1:0] vld_r;
  logic [SYM_DEPTH-1:0] vld_nxt;
  logic                 wr_v_r;
  logic [SYM_W-1:0]     wr_sym_r;
  logic [POS_W-1:0]     wr_pos_r;
  logic                 sc_clr;

  swdd_ram #(
    .WIDTH (POS_W),
    .DEPTH (SYM_DEPTH)
  ) u_swdd_ram (
    .clk     (clk),
    .we      (s1_v_r),
    .waddr   (s1_sym_r),
    .wdata   (s1_pos_r),
    .re_a    (in_acc),
    .raddr_a (in_ch.symbol),
    .rdata_a (rd_pos),
    .re_b    (1'b1),
    .raddr_b (sc_ptr_r),
    .rdata_b (sc_pos)
  );

  // Drop a stale entry unless it was rewritten in the read cycle or is being
  // rewritten now; ages of MAX_WINDOW and beyond can no longer shorten a run.
  assign sc_clr = sc_v1_r && vld_r[sc_e1_r]
               && ((pos_r - sc_pos) >= AGE_MAX)
               && !(wr_v_r && (wr_sym_r == sc_e1_r))
               && !(s1_v_r && (s1_sym_r == sc_e1_r));

  always_comb begin
    vld_nxt = vld_r;
    if (sc_clr) begin
      vld_nxt[sc_e1_r] = 1'b0;
    end
    if (s1_v_r) begin
      vld_nxt[s1_sym_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      sc_ptr_r <= '0;
      sc_v1_r  <= 1'b0;
      wr_v_r   <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      sc_ptr_r <= sc_ptr_r + ADDR_W'(1);
      sc_v1_r  <= 1'b1;
      wr_v_r   <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_e1_r  <= sc_ptr_r;
    wr_sym_r <= s1_sym_r;
    wr_pos_r <= s1_pos_r;
  end

  // ---------------------------------------------------------------- run tracker
  logic             fwd;
  logic [POS_W-1:0] prev_pos;
  logic             prev_ok;
  logic [POS_W-1:0] gap;
  logic [RUN_W-1:0] run_r;
  logic [RUN_W-1:0] run_cand;
  logic [RUN_W-1:0] run_nxt;
  logic             hit;
  logic             flag;
  logic             first;
  logic             marker_r;

  // Forward last cycle's write: the RAM returned the old value for that address
  assign fwd      = wr_v_r && (wr_sym_r == s1_sym_r);
  assign prev_pos = fwd ? wr_pos_r : rd_pos;
  assign prev_ok  = fwd || vld_r[s1_sym_r];
  assign gap      = s1_pos_r - prev_pos;
  assign run_cand = (run_r == RUN_MAX) ? run_r : run_r + RUN_W'(1);
  assign hit      = prev_ok && (gap < POS_W'(run_cand));
  assign run_nxt  = hit ? gap[RUN_W-1:0] : run_cand;
  assign flag     = run_nxt >= win_eff;
  assign first    = flag && !marker_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= '0;
      marker_r <= 1'b0;
    end else if (s1_v_r) begin
      run_r    <= run_nxt;
      marker_r <= marker_r || flag;
    end
  end

  // ---------------------------------------------------------------- output queue
  swdd_result_t    q_r [OQ_DEPTH];
  swdd_result_t    q_head;
  logic [QP_W-1:0] q_wp_r;
  logic [QP_W-1:0] q_rp_r;
  logic            q_pop;

  assign q_head                 = q_r[q_rp_r];
  assign out_ch.valid           = (q_cnt_r != '0);
  assign out_ch.window_distinct = q_head.window_distinct;
  assign out_ch.first_marker    = q_head.first_marker;
  assign out_ch.bytes_seen      = q_head.bytes_seen;
  assign q_pop                  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (s1_v_r) begin
        q_wp_r <= (32'(q_wp_r) == OQ_DEPTH - 1) ? '0 : q_wp_r + QP_W'(1);
      end
      if (q_pop) begin
        q_rp_r <= (32'(q_rp_r) == OQ_DEPTH - 1) ? '0 : q_rp_r + QP_W'(1);
      end
      if (s1_v_r && !q_pop) begin
        q_cnt_r <= q_cnt_r + QC_W'(1);
      end else if (!s1_v_r && q_pop) begin
        q_cnt_r <= q_cnt_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      q_r[q_wp_r] <= '{window_distinct: flag, first_marker: first, bytes_seen: s1_cnt_r};
    end
  end

endmodule

[rtl/core/swdd_ram.sv]
// Generic RAM: one write port, two registered read ports.
module swdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

[rtl/core/swdd_checker.sv]
// Port-level checker for the sliding-window distinct detector, bound to the top level.
module swdd_checker
  import swdd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_window_distinct,
  input logic             out_first_marker,
  input logic [CNT_W-1:0] out_bytes_seen
);

  logic             out_acc;
  logic [CNT_W-1:0] exp_cnt_r;
  logic [CNT_W-1:0] exp_cnt_nxt;
  logic             first_seen_r;

  assign out_acc     = out_valid && out_ready;
  assign exp_cnt_nxt = (exp_cnt_r == '1) ? exp_cnt_r : exp_cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cnt_r    <= '0;
      first_seen_r <= 1'b0;
    end else if (out_acc) begin
      exp_cnt_r    <= exp_cnt_nxt;
      first_seen_r <= first_seen_r || out_first_marker;
    end
  end

  // Results leave in order, one per beat: the count runs up by one and saturates
  a_count_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_bytes_seen == exp_cnt_nxt))
    else $error("bytes_seen out of sequence");

  a_first_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_first_marker) |-> out_window_distinct)
    else $error("first_marker without window_distinct");

  a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && first_seen_r) |-> !out_first_marker)
    else $error("first_marker repeated");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_bytes_seen)
                                   && $stable(out_window_distinct)
                                   && $stable(out_first_marker)))
    else $error("stalled result beat changed");

endmodule

bind sliding_window_distinct_detector_unit swdd_checker u_swdd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_window_distinct (out_ch.window_distinct),
  .out_first_marker    (out_ch.first_marker),
  .out_bytes_seen      (out_ch.bytes_seen)
);
